### rtl/detection_wake_qualifier_macros.svh
// Assertion macros for the detection wake qualifier.
// Each macro expects clk_i in the scope where it is used; DWQ_ASSERT also expects rst_ni.
`ifndef DETECTION_WAKE_QUALIFIER_MACROS_SVH
`define DETECTION_WAKE_QUALIFIER_MACROS_SVH

`ifndef SYNTHESIS

`define DWQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`define DWQ_ASSERT_ANY(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`else

`define DWQ_ASSERT(label, prop, msg)

`define DWQ_ASSERT_ANY(label, prop, msg)

`endif

`endif

### rtl/dwq_pkg.sv
package dwq_pkg;

  localparam int unsigned ADDR_W  = 5;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned TIME_W  = 63;
  localparam int unsigned HITS_W  = 7;
  localparam int unsigned SECS_W  = 12;
  localparam int unsigned THR_W   = 32;

  localparam logic [THR_W-1:0] US_PER_SECOND = 32'd1000000;

  localparam logic [2:0] REG_TARGET_CLASS     = 3'd0;
  localparam logic [2:0] REG_SCORE_THRESHOLD  = 3'd1;
  localparam logic [2:0] REG_VALIDATE_SECONDS = 3'd2;
  localparam logic [2:0] REG_DEBOUNCE_SECONDS = 3'd3;
  localparam logic [2:0] REG_COOLDOWN_SECONDS = 3'd4;

  localparam logic [7:0]        RST_TARGET_CLASS     = 8'd0;
  localparam logic [6:0]        RST_SCORE_THRESHOLD  = 7'd75;
  localparam logic [SECS_W-1:0] RST_VALIDATE_SECONDS = 12'd2;
  localparam logic [SECS_W-1:0] RST_DEBOUNCE_SECONDS = 12'd1;
  localparam logic [SECS_W-1:0] RST_COOLDOWN_SECONDS = 12'd8;

  localparam logic [1:0] KIND_BOX    = 2'd0;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  localparam logic [1:0] QC_IDLE       = 2'd0;
  localparam logic [1:0] QC_VALIDATING = 2'd1;
  localparam logic [1:0] QC_COOLDOWN   = 2'd2;

  typedef enum logic [2:0] {
    QS_IDLE       = 3'b001,
    QS_VALIDATING = 3'b010,
    QS_COOLDOWN   = 3'b100
  } qual_state_e;

  typedef struct packed {
    logic              wake;
    logic [HITS_W-1:0] match_count;
    logic [1:0]        qual_state;
  } result_t;

  function automatic logic [1:0] state_code(input qual_state_e st);
    logic [1:0] code;
    unique case (st)
      QS_IDLE:       code = QC_IDLE;
      QS_VALIDATING: code = QC_VALIDATING;
      QS_COOLDOWN:   code = QC_COOLDOWN;
      default:       code = QC_IDLE;
    endcase
    return code;
  endfunction

  function automatic logic [THR_W-1:0] secs_to_us(input logic [SECS_W-1:0] secs);
    return THR_W'(secs) * US_PER_SECOND;
  endfunction

endpackage

### rtl/detection_wake_qualifier.sv
// Channel  | Direction | Handshake                     | Beat
// ---------+-----------+-------------------------------+---------------------------------------
// input    | in        | in_valid_i / in_ready_o       | one detection or empty-frame marker
// result   | out       | out_valid_o / out_ready_i     | one frame result per frame_last beat
// config   | in        | APB psel/penable/pwrite/pready| one register write or read
//
// An input beat is taken every cycle while the skid register is empty; its match is counted
// at once and, on the last beat of a frame, the state update and result are formed in the
// same cycle. A result is loaded into the output register as its frame's last beat is accepted
// if free or being emptied, or from the skid register once the result ahead of it is taken.
// A two-entry output stage (result register plus skid register) lets input continue while
// a result waits; input stalls only when both entries are full.
// Reset is asynchronous and active low; it clears the configuration, state and valid
// registers, while the result data registers hold no reset value.
`include "detection_wake_qualifier_macros.svh"

module detection_wake_qualifier
  import dwq_pkg::*;
#(
  parameter int unsigned MAX_DETECTIONS = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,

  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [TIME_W-1:0]     frame_time_us_i,
  input  logic [1:0]            det_kind_i,
  input  logic                  det_valid_i,
  input  logic [7:0]            det_target_i,
  input  logic [6:0]            det_score_i,
  input  logic                  frame_last_i,

  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  wake_o,
  output logic [HITS_W-1:0]     match_count_o,
  output logic [1:0]            qual_state_o,

  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_W-1:0]     paddr,
  input  logic [DATA_W-1:0]     pwdata,
  output logic [DATA_W-1:0]     prdata,
  output logic                  pready
);

  localparam logic [HITS_W-1:0] HIT_CAP =
    (MAX_DETECTIONS > 127) ? 7'd127 : HITS_W'(MAX_DETECTIONS);

  logic [7:0]        target_class_q;
  logic [6:0]        score_threshold_q;
  logic [SECS_W-1:0] validate_s_q, debounce_s_q, cooldown_s_q;
  logic [THR_W-1:0]  validate_us_q, debounce_us_q, cooldown_us_q;
  logic [2:0]        reg_index;
  logic              cfg_write;
  logic [THR_W-1:0]  wr_us;

  assign pready    = 1'b1;
  assign reg_index = paddr[4:2];
  assign cfg_write = psel & penable & pwrite;
  assign wr_us     = secs_to_us(pwdata[SECS_W-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_class_q    <= RST_TARGET_CLASS;
      score_threshold_q <= RST_SCORE_THRESHOLD;
      validate_s_q      <= RST_VALIDATE_SECONDS;
      debounce_s_q      <= RST_DEBOUNCE_SECONDS;
      cooldown_s_q      <= RST_COOLDOWN_SECONDS;
      validate_us_q     <= secs_to_us(RST_VALIDATE_SECONDS);
      debounce_us_q     <= secs_to_us(RST_DEBOUNCE_SECONDS);
      cooldown_us_q     <= secs_to_us(RST_COOLDOWN_SECONDS);
    end else if (cfg_write) begin
      unique case (reg_index)
        REG_TARGET_CLASS:     target_class_q    <= pwdata[7:0];
        REG_SCORE_THRESHOLD:  score_threshold_q <= pwdata[6:0];
        REG_VALIDATE_SECONDS: begin
          validate_s_q  <= pwdata[SECS_W-1:0];
          validate_us_q <= wr_us;
        end
        REG_DEBOUNCE_SECONDS: begin
          debounce_s_q  <= pwdata[SECS_W-1:0];
          debounce_us_q <= wr_us;
        end
        REG_COOLDOWN_SECONDS: begin
          cooldown_s_q  <= pwdata[SECS_W-1:0];
          cooldown_us_q <= wr_us;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      REG_TARGET_CLASS:     prdata = DATA_W'(target_class_q);
      REG_SCORE_THRESHOLD:  prdata = DATA_W'(score_threshold_q);
      REG_VALIDATE_SECONDS: prdata = DATA_W'(validate_s_q);
      REG_DEBOUNCE_SECONDS: prdata = DATA_W'(debounce_s_q);
      REG_COOLDOWN_SECONDS: prdata = DATA_W'(cooldown_s_q);
      default:              prdata = '0;
    endcase
  end

  qual_state_e       state_q, state_d;
  logic [TIME_W-1:0] phase_start_q, phase_start_d;
  logic [TIME_W-1:0] last_seen_q, last_seen_d;
  logic              pending_q, pending_d;
  logic              frame_hit_q, frame_hit_nx;
  logic [HITS_W-1:0] frame_hits_q, frame_hits_nx;

  logic              in_accept;
  logic              is_match, is_box, counts, detected, wake;
  logic [TIME_W-1:0] phase_eff;
  logic [TIME_W:0]   phase_diff, seen_diff;
  logic [THR_W-1:0]  phase_thr;
  logic              phase_reached, seen_reached;
  result_t           res;

  logic              out_valid_q, skid_valid_q;
  result_t           out_q, skid_q;
  logic              out_take, push;

  assign in_ready_o = ~skid_valid_q;
  assign in_accept  = in_valid_i & in_ready_o;

  assign is_box   = (det_kind_i == KIND_BOX);
  assign is_match = det_valid_i && (det_kind_i != KIND_UNUSED)
                    && (det_target_i == target_class_q) && (det_score_i > score_threshold_q);
  assign counts   = is_match && !(is_box && frame_hit_q);

  assign frame_hit_nx  = frame_hit_q | (is_match & is_box);
  assign frame_hits_nx = (counts && (frame_hits_q < HIT_CAP)) ? frame_hits_q + 7'd1
                                                               : frame_hits_q;
  assign detected      = (frame_hits_nx != '0);

  assign phase_eff  = pending_q ? frame_time_us_i : phase_start_q;
  assign phase_thr  = (state_q == QS_VALIDATING) ? validate_us_q : cooldown_us_q;
  assign phase_diff = {1'b0, frame_time_us_i} - {1'b0, phase_eff};
  assign seen_diff  = {1'b0, frame_time_us_i} - {1'b0, last_seen_q};

  assign phase_reached = !phase_diff[TIME_W]
                         && (phase_diff[TIME_W-1:0] >= {31'b0, phase_thr});
  assign seen_reached  = !seen_diff[TIME_W]
                         && (seen_diff[TIME_W-1:0] >= {31'b0, debounce_us_q});

  always_comb begin
    state_d       = state_q;
    phase_start_d = phase_eff;
    last_seen_d   = last_seen_q;
    pending_d     = 1'b0;
    wake          = 1'b0;
    unique case (state_q)
      QS_IDLE: begin
        if (detected) begin
          state_d       = QS_VALIDATING;
          phase_start_d = frame_time_us_i;
          last_seen_d   = frame_time_us_i;
        end
      end
      QS_VALIDATING: begin
        if (detected) begin
          last_seen_d = frame_time_us_i;
          if (phase_reached) begin
            wake      = 1'b1;
            state_d   = QS_COOLDOWN;
            pending_d = 1'b1;
          end
        end else if (seen_reached) begin
          state_d     = QS_IDLE;
          last_seen_d = '0;
        end
      end
      QS_COOLDOWN: begin
        if (!detected && phase_reached) begin
          state_d = QS_IDLE;
        end
      end
      default: state_d = QS_IDLE;
    endcase
  end

  assign res.wake        = wake;
  assign res.match_count = frame_hits_nx;
  assign res.qual_state  = state_code(state_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= QS_IDLE;
      phase_start_q <= '0;
      last_seen_q   <= '0;
      pending_q     <= 1'b0;
      frame_hit_q   <= 1'b0;
      frame_hits_q  <= '0;
    end else if (in_accept) begin
      if (frame_last_i) begin
        state_q       <= state_d;
        phase_start_q <= phase_start_d;
        last_seen_q   <= last_seen_d;
        pending_q     <= pending_d;
        frame_hit_q   <= 1'b0;
        frame_hits_q  <= '0;
      end else begin
        frame_hit_q  <= frame_hit_nx;
        frame_hits_q <= frame_hits_nx;
      end
    end
  end

  assign out_take = out_valid_q & out_ready_i;
  assign push     = in_accept & frame_last_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_take) begin
        skid_valid_q <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid_q || out_take) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_take) begin
        out_q <= skid_q;
      end
    end else if (push) begin
      if (!out_valid_q || out_take) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign wake_o        = out_q.wake;
  assign match_count_o = out_q.match_count;
  assign qual_state_o  = out_q.qual_state;

  `DWQ_ASSERT(a_skid_behind_out, skid_valid_q |-> out_valid_q, "Skid entry held without a result in front of it.")
  `DWQ_ASSERT(a_wake_in_cooldown, (out_valid_o && wake_o) |-> (qual_state_o == QC_COOLDOWN), "Wake result not reporting cooldown.")
  `DWQ_ASSERT(a_pending_in_cooldown, pending_q |-> (state_q == QS_COOLDOWN), "Cooldown start pending outside cooldown.")
  `DWQ_ASSERT(a_no_result_midframe, (in_accept && !frame_last_i && !out_valid_q && !skid_valid_q) |=> !out_valid_q, "Result produced by a mid-frame beat.")
  `DWQ_ASSERT(a_count_capped, out_valid_o |-> (match_count_o <= HIT_CAP), "Match count above its cap.")

endmodule

### tb/detection_wake_qualifier_tb.sv
module detection_wake_qualifier_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dwq_pkg::*;

  localparam int unsigned MAX_DETECTIONS = 64;
  localparam int unsigned HIT_CAP        = (MAX_DETECTIONS > 127) ? 127 : MAX_DETECTIONS;
  localparam int unsigned PHASE_ITEMS    = 115;
  localparam int unsigned SETTLE_CYCLES  = 4;
  localparam int unsigned CYCLE_LIMIT    = 1000000;
  localparam logic [1:0]  KIND_CLASS     = 2'd1;
  localparam logic [1:0]  KIND_POINT     = 2'd2;
  localparam logic [TIME_W-1:0] TS_MAX   = '1;

  typedef struct packed {
    logic [TIME_W-1:0] ts;
    logic [1:0]        kind;
    logic              dv;
    logic [7:0]        tgt;
    logic [6:0]        score;
    logic              last;
  } det_item_t;

  typedef struct packed {
    det_item_t item;
    logic      typed;
    result_t   want;
  } stim_row_t;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [TIME_W-1:0] frame_time_us_i;
  logic [1:0]        det_kind_i;
  logic              det_valid_i;
  logic [7:0]        det_target_i;
  logic [6:0]        det_score_i;
  logic              frame_last_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic              wake_o;
  logic [HITS_W-1:0] match_count_o;
  logic [1:0]        qual_state_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  logic [7:0]        cfg_target;
  logic [6:0]        cfg_threshold;
  logic [SECS_W-1:0] cfg_validate_s;
  logic [SECS_W-1:0] cfg_debounce_s;
  logic [SECS_W-1:0] cfg_cooldown_s;

  logic [1:0]        fsm;
  logic [63:0]       phase_start_us;
  logic [63:0]       last_seen_us;
  logic              cool_pending;
  logic              box_counted;
  logic [HITS_W-1:0] frame_matches;

  result_t           frame_results_q[$];
  int                mismatches;
  int                cycle_count;
  bit                send_calm;
  bit                recv_calm;

  detection_wake_qualifier #(
    .MAX_DETECTIONS(MAX_DETECTIONS)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .frame_time_us_i(frame_time_us_i),
    .det_kind_i     (det_kind_i),
    .det_valid_i    (det_valid_i),
    .det_target_i   (det_target_i),
    .det_score_i    (det_score_i),
    .frame_last_i   (frame_last_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .wake_o         (wake_o),
    .match_count_o  (match_count_o),
    .qual_state_o   (qual_state_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  task automatic report(input string what, input logic [63:0] want, input logic [63:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch in %s: expected %0d, got %0d", what, want, got);
    end
  endtask

  function automatic bit reached(input logic [63:0] now, input logic [63:0] since,
                                 input logic [SECS_W-1:0] secs);
    return (now >= since) && ((now - since) >= 64'(secs) * 64'(US_PER_SECOND));
  endfunction

  function automatic bit qualify_item(input det_item_t it, output result_t res);
    bit          counts;
    bit          seen;
    bit          woke;
    logic [63:0] now;
    woke = 1'b0;
    if (it.dv && it.kind != KIND_UNUSED && it.tgt == cfg_target &&
        it.score > cfg_threshold) begin
      counts = 1'b1;
      if (it.kind == KIND_BOX) begin
        counts = !box_counted;
        box_counted = 1'b1;
      end
      if (counts && frame_matches < HIT_CAP) frame_matches++;
    end
    res = '0;
    if (!it.last) return 1'b0;
    seen = frame_matches != 0;
    now = {1'b0, it.ts};
    if (cool_pending) begin
      phase_start_us = now;
      cool_pending = 1'b0;
    end
    case (fsm)
      QC_IDLE: begin
        if (seen) begin
          fsm = QC_VALIDATING;
          phase_start_us = now;
          last_seen_us = now;
        end
      end
      QC_VALIDATING: begin
        if (seen) begin
          last_seen_us = now;
          woke = reached(now, phase_start_us, cfg_validate_s);
        end else if (reached(now, last_seen_us, cfg_debounce_s)) begin
          fsm = QC_IDLE;
          last_seen_us = '0;
        end
      end
      default: begin
        if (!seen && reached(now, phase_start_us, cfg_cooldown_s)) fsm = QC_IDLE;
      end
    endcase
    if (woke) begin
      fsm = QC_COOLDOWN;
      cool_pending = 1'b1;
    end
    res.wake = woke;
    res.match_count = frame_matches;
    res.qual_state = fsm;
    box_counted = 1'b0;
    frame_matches = '0;
    return 1'b1;
  endfunction

  function automatic int pick_gap(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_item(input det_item_t it);
    int gap;
    gap = pick_gap(send_calm);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    frame_time_us_i <= it.ts;
    det_kind_i      <= it.kind;
    det_valid_i     <= it.dv;
    det_target_i    <= it.tgt;
    det_score_i     <= it.score;
    frame_last_i    <= it.last;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (frame_results_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [DATA_W-1:0] val);
    logic [DATA_W-1:0] want;
    want = '0;
    case (idx)
      REG_TARGET_CLASS: begin
        want = DATA_W'(val[7:0]);
        cfg_target = val[7:0];
      end
      REG_SCORE_THRESHOLD: begin
        want = DATA_W'(val[6:0]);
        cfg_threshold = val[6:0];
      end
      REG_VALIDATE_SECONDS: begin
        want = DATA_W'(val[SECS_W-1:0]);
        cfg_validate_s = val[SECS_W-1:0];
      end
      REG_DEBOUNCE_SECONDS: begin
        want = DATA_W'(val[SECS_W-1:0]);
        cfg_debounce_s = val[SECS_W-1:0];
      end
      REG_COOLDOWN_SECONDS: begin
        want = DATA_W'(val[SECS_W-1:0]);
        cfg_cooldown_s = val[SECS_W-1:0];
      end
      default: begin
      end
    endcase
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== want) report("register read-back", want, prdata);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // The receiver stalls on its own schedule, independent of the sender.
  initial begin
    int stall;
    stall = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        stall--;
      end else begin
        out_ready_i <= 1'b1;
        stall = pick_gap(recv_calm);
      end
    end
  end

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (frame_results_q.size() == 0) begin
        report("unexpected frame result", '0, {wake_o, match_count_o, qual_state_o});
      end else begin
        want = frame_results_q.pop_front();
        if (wake_o !== want.wake) report("wake", want.wake, wake_o);
        if (match_count_o !== want.match_count) begin
          report("match_count", want.match_count, match_count_o);
        end
        if (qual_state_o !== want.qual_state) report("qual_state", want.qual_state, qual_state_o);
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("[detection_wake_qualifier] ERROR");
    $finish;
  end

  initial begin
    stim_row_t         rows[$];
    det_item_t         it;
    result_t           got;
    logic [TIME_W-1:0] now_us;
    logic [63:0]       rnd64;
    logic [63:0]       span;
    logic [63:0]       step;
    logic [63:0]       nxt;
    logic [7:0]        v_target;
    logic [6:0]        v_thr;
    logic [SECS_W-1:0] v_val;
    logic [SECS_W-1:0] v_deb;
    logic [SECS_W-1:0] v_cool;
    int                flen;
    int                phase_items;
    int                r;
    bit                dense;
    bit                hot;
    bit                want_match;
    bit                paused;

    mismatches      = 0;
    send_calm       = 1'b0;
    recv_calm       = 1'b0;
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    frame_time_us_i = '0;
    det_kind_i      = KIND_BOX;
    det_valid_i     = 1'b0;
    det_target_i    = '0;
    det_score_i     = '0;
    frame_last_i    = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;

    cfg_target      = RST_TARGET_CLASS;
    cfg_threshold   = RST_SCORE_THRESHOLD;
    cfg_validate_s  = RST_VALIDATE_SECONDS;
    cfg_debounce_s  = RST_DEBOUNCE_SECONDS;
    cfg_cooldown_s  = RST_COOLDOWN_SECONDS;
    fsm             = QC_IDLE;
    phase_start_us  = '0;
    last_seen_us    = '0;
    cool_pending    = 1'b0;
    box_counted     = 1'b0;
    frame_matches   = '0;
    now_us          = '0;

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset settings: target 0, threshold 75, validate 2 s, debounce 1 s, cooldown 8 s.
    rows.push_back('{'{63'd0, KIND_BOX, 1'b0, 8'd0, 7'd0, 1'b1}, 1'b1,
                     '{1'b0, 7'd0, QC_IDLE}});
    rows.push_back('{'{63'd0, KIND_CLASS, 1'b1, 8'd0, 7'd76, 1'b1}, 1'b1,
                     '{1'b0, 7'd1, QC_VALIDATING}});
    rows.push_back('{'{63'd1000000, KIND_BOX, 1'b0, 8'd0, 7'd0, 1'b1}, 1'b1,
                     '{1'b0, 7'd0, QC_IDLE}});
    rows.push_back('{'{63'd1000100, KIND_BOX, 1'b1, 8'd0, 7'd76, 1'b0}, 1'b0, '0});
    rows.push_back('{'{63'd1000100, KIND_BOX, 1'b1, 8'd0, 7'd100, 1'b0}, 1'b0, '0});
    rows.push_back('{'{63'd1000100, KIND_CLASS, 1'b1, 8'd0, 7'd76, 1'b1}, 1'b1,
                     '{1'b0, 7'd2, QC_VALIDATING}});
    rows.push_back('{'{63'd1500000, KIND_POINT, 1'b1, 8'd0, 7'd75, 1'b1}, 1'b0, '0});
    rows.push_back('{'{63'd2500100, KIND_UNUSED, 1'b1, 8'd0, 7'd127, 1'b1}, 1'b0, '0});
    rows.push_back('{'{63'd3000000, KIND_POINT, 1'b1, 8'd255, 7'd100, 1'b0}, 1'b0, '0});
    rows.push_back('{'{63'd3000000, KIND_CLASS, 1'b0, 8'd0, 7'd127, 1'b1}, 1'b0, '0});
    rows.push_back('{'{63'd3000000, KIND_POINT, 1'b1, 8'd0, 7'd127, 1'b1}, 1'b0, '0});
    rows.push_back('{'{63'd2000000, KIND_BOX, 1'b0, 8'd0, 7'd0, 1'b1}, 1'b0, '0});
    rows.push_back('{'{63'd5000000, KIND_CLASS, 1'b1, 8'd0, 7'd90, 1'b1}, 1'b0, '0});
    rows.push_back('{'{63'd6000000, KIND_BOX, 1'b0, 8'd0, 7'd0, 1'b1}, 1'b0, '0});
    rows.push_back('{'{63'd20000000, KIND_CLASS, 1'b1, 8'd0, 7'd90, 1'b1}, 1'b0, '0});
    rows.push_back('{'{63'd14000000, KIND_BOX, 1'b0, 8'd0, 7'd0, 1'b1}, 1'b0, '0});
    rows.push_back('{'{TS_MAX, KIND_CLASS, 1'b1, 8'd0, 7'd100, 1'b1}, 1'b0, '0});
    rows.push_back('{'{TS_MAX, KIND_BOX, 1'b1, 8'd0, 7'd100, 1'b0}, 1'b0, '0});
    rows.push_back('{'{TS_MAX, KIND_BOX, 1'b1, 8'd0, 7'd100, 1'b1}, 1'b0, '0});
    rows.push_back('{'{63'd7, KIND_BOX, 1'b1, 8'd0, 7'd76, 1'b1}, 1'b0, '0});

    foreach (rows[i]) begin
      send_item(rows[i].item);
      if (qualify_item(rows[i].item, got)) begin
        frame_results_q.push_back(rows[i].typed ? rows[i].want : got);
      end
    end

    for (int ph = 1; ph <= 7; ph++) begin
      drain();
      case (ph)
        1: begin
          v_target = 8'd255; v_thr = 7'd0;
          v_val = 12'd0; v_deb = 12'd0; v_cool = 12'd0;
        end
        2: begin
          v_target = 8'hAA; v_thr = 7'd100;
          v_val = 12'd3600; v_deb = 12'd3600; v_cool = 12'd3600;
        end
        3: begin
          v_target = 8'h55; v_thr = 7'd127;
          v_val = 12'd4095; v_deb = 12'd4095; v_cool = 12'd4095;
        end
        4: begin
          v_target = 8'd0; v_thr = 7'd50;
          v_val = 12'd1; v_deb = 12'd2; v_cool = 12'd3;
        end
        6: begin
          v_target = 8'($urandom_range(0, 255)); v_thr = 7'($urandom_range(0, 127));
          v_val = 12'($urandom_range(0, 4095)); v_deb = 12'($urandom_range(0, 4095));
          v_cool = 12'($urandom_range(0, 4095));
        end
        default: begin
          v_target = 8'($urandom_range(0, 255)); v_thr = 7'($urandom_range(0, 100));
          v_val = 12'($urandom_range(0, 5)); v_deb = 12'($urandom_range(0, 5));
          v_cool = 12'($urandom_range(0, 5));
        end
      endcase
      write_reg(REG_TARGET_CLASS, DATA_W'(v_target));
      write_reg(REG_SCORE_THRESHOLD, DATA_W'(v_thr));
      write_reg(REG_VALIDATE_SECONDS, DATA_W'(v_val));
      write_reg(REG_DEBOUNCE_SECONDS, DATA_W'(v_deb));
      write_reg(REG_COOLDOWN_SECONDS, DATA_W'(v_cool));

      phase_items = 0;
      paused = 1'b0;
      while (phase_items < PHASE_ITEMS) begin
        if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
        if ($urandom_range(0, 39) == 0) recv_calm = !recv_calm;

        // Steps are scaled to the debounce time, so that sightings are sustained
        // or lapse with about equal odds; now and then the clock jumps or runs back.
        span = (64'(cfg_debounce_s) + 64'd1) * 64'(US_PER_SECOND);
        if ($urandom_range(0, 7) == 0) begin
          span = (64'(cfg_validate_s) + 64'(cfg_cooldown_s) + 64'd1) * 64'(US_PER_SECOND);
        end
        rnd64 = {$urandom, $urandom};
        step = rnd64 % span;
        if ($urandom_range(0, 3) == 0) begin
          step = 64'($urandom_range(0, int'(cfg_debounce_s) + 1)) * 64'(US_PER_SECOND);
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
          rnd64 = {$urandom, $urandom};
          now_us = rnd64[TIME_W-1:0];
        end else if (r < 8) begin
          now_us = ({1'b0, now_us} > step) ? now_us - step[TIME_W-1:0] : '0;
        end else begin
          nxt = {1'b0, now_us} + step;
          now_us = nxt[63] ? step[TIME_W-1:0] : nxt[TIME_W-1:0];
        end

        dense = $urandom_range(0, 99) < 3;
        hot = $urandom_range(0, 99) < 55;
        flen = dense ? $urandom_range(66, 90) : $urandom_range(1, 4);
        for (int k = 0; k < flen; k++) begin
          want_match = dense || (hot ? $urandom_range(0, 3) != 0 : $urandom_range(0, 5) == 0);
          it.ts = now_us;
          if (dense) begin
            it.kind = 2'($urandom_range(1, 2));
          end else if ($urandom_range(0, 19) == 0) begin
            it.kind = KIND_UNUSED;
          end else begin
            it.kind = 2'($urandom_range(0, 2));
          end
          it.dv = dense || $urandom_range(0, 11) != 0;
          it.tgt = want_match ? cfg_target : 8'($urandom_range(0, 255));
          if (want_match && cfg_threshold != 7'd127) begin
            it.score = 7'($urandom_range(int'(cfg_threshold) + 1, 127));
          end else begin
            it.score = 7'($urandom_range(0, 127));
          end
          it.last = (k == flen - 1);
          send_item(it);
          if (qualify_item(it, got)) frame_results_q.push_back(got);
        end
        phase_items += flen;
        if (!paused && phase_items >= PHASE_ITEMS / 2) begin
          drain();
          paused = 1'b1;
        end
      end
    end

    drain();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[detection_wake_qualifier] OK");
    end else begin
      $display("[detection_wake_qualifier] ERROR");
    end
    $finish;
  end

endmodule
